/* design/adsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int unsigned GAIN_W     = 17;
   localparam int unsigned STAGE_W    = 3;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // full scale gain, 1.0 in unsigned Q1.16
   localparam logic [GAIN_W-1:0] FULL_SCALE = GAIN_W'(65536);
   localparam logic [GAIN_W-1:0] GAIN_ZERO  = '0;

   // envelope stage codes, as seen on the result channel
   typedef enum logic [STAGE_W-1:0] {
      STG_IDLE    = 3'd0,
      STG_ATTACK  = 3'd1,
      STG_DECAY   = 3'd2,
      STG_SUSTAIN = 3'd3,
      STG_RELEASE = 3'd4
   } stage_type;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_ATTACK_STEP   = 2'd0,
      REG_DECAY_STEP    = 2'd1,
      REG_SUSTAIN_LEVEL = 2'd2,
      REG_RELEASE_STEP  = 2'd3
   } reg_index_type;

   // configuration as seen by the step logic
   typedef struct packed {
      logic [GAIN_W-1:0] attack_step;
      logic [GAIN_W-1:0] decay_step;
      logic [GAIN_W-1:0] sustain_level;
      logic [GAIN_W-1:0] release_step;
   } cfg_type;

   // envelope state: stage and current gain
   typedef struct packed {
      stage_type         stage;
      logic [GAIN_W-1:0] level;
   } env_type;

endpackage

/* design/adsr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_step
// Next-state logic for one sample tick: trigger, gate check, stage update.
// ----------------------------------------------------------------------------
module adsr_step
   import adsr_pkg::*;
(
   input  cfg_type cfg,
   input  env_type cur,
   input  logic    gate,
   input  logic    trigger,
   output env_type nxt
);

   logic [GAIN_W-1:0] sus;
   logic [GAIN_W:0]   attack_sum;
   logic [GAIN_W:0]   decay_floor;
   stage_type         eff_stage;

   // sustain level clamped to full scale
   assign sus = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;

   assign attack_sum  = {1'b0, cur.level} + {1'b0, cfg.attack_step};
   assign decay_floor = {1'b0, sus} + {1'b0, cfg.decay_step};

   // trigger first, then a low gate sends active stages to release
   always_comb begin
      eff_stage = cur.stage;
      if (trigger) begin
         eff_stage = STG_ATTACK;
      end
      if (!gate && (eff_stage == STG_ATTACK || eff_stage == STG_DECAY ||
                    eff_stage == STG_SUSTAIN)) begin
         eff_stage = STG_RELEASE;
      end
   end

   // stage update with saturating ramps
   always_comb begin
      nxt.stage = eff_stage;
      nxt.level = cur.level;
      unique case (eff_stage)
         STG_ATTACK: begin
            if (attack_sum >= {1'b0, FULL_SCALE}) begin
               nxt.level = FULL_SCALE;
               nxt.stage = STG_DECAY;
            end else begin
               nxt.level = attack_sum[GAIN_W-1:0];
            end
         end
         STG_DECAY: begin
            if ({1'b0, cur.level} <= decay_floor) begin
               nxt.level = sus;
               nxt.stage = STG_SUSTAIN;
            end else begin
               nxt.level = cur.level - cfg.decay_step;
            end
         end
         STG_SUSTAIN: begin
            nxt.level = sus;
         end
         STG_RELEASE: begin
            if (cur.level <= cfg.release_step) begin
               nxt.level = GAIN_ZERO;
               nxt.stage = STG_IDLE;
            end else begin
               nxt.level = cur.level - cfg.release_step;
            end
         end
         default: begin
            nxt.level = GAIN_ZERO;
            nxt.stage = STG_IDLE;
         end
      endcase
   end

endmodule

/* design/adsr_envelope_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope, one tick per request transaction, with CSR port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_ready  req_gate, req_trigger
//  rsp_      out        rsp_valid/rsp_ready  rsp_gain[16:0], rsp_stage[2:0]
//  csr_      in/out     psel/penable/pready  paddr[3:0], pwdata, prdata
//
//  A tick passes an input register and then a result register; one transaction
//  per cycle is sustained while the result channel is not stalled.
//  Reset clears the envelope to idle with zero gain and all CSRs to zero.
//  A stalled result holds; the input register refills as the result drains.
// ----------------------------------------------------------------------------
module adsr_envelope_generator
   import adsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_gate,
   input  logic                  req_trigger,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GAIN_W-1:0]     rsp_gain,
   output logic [STAGE_W-1:0]    rsp_stage,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   reg_index_type     csr_index;
   logic              csr_write;

   logic              in_valid_ff;
   logic              in_valid_in;
   logic              gate_ff;
   logic              trigger_ff;

   env_type           env_ff;
   env_type           env_in;
   env_type           env_nxt;

   logic              out_valid_ff;
   logic              out_valid_in;
   logic [GAIN_W-1:0] out_gain_ff;
   stage_type         out_stage_ff;

   logic              out_free;
   logic              advance;

   // csr decode
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ATTACK_STEP:   cfg_in.attack_step   = csr_pwdata[GAIN_W-1:0];
            REG_DECAY_STEP:    cfg_in.decay_step    = csr_pwdata[GAIN_W-1:0];
            REG_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_pwdata[GAIN_W-1:0];
            REG_RELEASE_STEP:  cfg_in.release_step  = csr_pwdata[GAIN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // csr read mux
   always_comb begin
      unique case (csr_index)
         REG_ATTACK_STEP:   csr_prdata = CSR_DATA_W'(cfg_ff.attack_step);
         REG_DECAY_STEP:    csr_prdata = CSR_DATA_W'(cfg_ff.decay_step);
         REG_SUSTAIN_LEVEL: csr_prdata = CSR_DATA_W'(cfg_ff.sustain_level);
         REG_RELEASE_STEP:  csr_prdata = CSR_DATA_W'(cfg_ff.release_step);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline flow control
   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         gate_ff    <= req_gate;
         trigger_ff <= req_trigger;
      end
   end

   // envelope step
   adsr_step u_step (
      .cfg     (cfg_ff),
      .cur     (env_ff),
      .gate    (gate_ff),
      .trigger (trigger_ff),
      .nxt     (env_nxt)
   );

   assign env_in = advance ? env_nxt : env_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff.stage <= STG_IDLE;
         env_ff.level <= GAIN_ZERO;
      end else begin
         env_ff <= env_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_gain_ff  <= env_nxt.level;
         out_stage_ff <= env_nxt.stage;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_gain  = out_gain_ff;
   assign rsp_stage = out_stage_ff;

   // checks
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_gain_ff <= FULL_SCALE))
      else $error("gain above full scale");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_stage_ff == STG_IDLE) |-> (out_gain_ff == GAIN_ZERO))
      else $error("idle stage with nonzero gain");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff && out_gain_ff == env_ff.level &&
                   out_stage_ff == env_ff.stage))
      else $error("result does not match envelope state");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(env_ff))
      else $error("envelope state changed without a tick");

endmodule
